[design/mkcc_pkg.sv]
`default_nettype none

package mkcc_pkg;

  // Alphanumeric zone: key below 48 and column below 6.
  localparam logic [5:0] KeyZoneLimit   = 6'd48;
  localparam logic [2:0] ColZoneLimit   = 3'd6;
  // A chord is two zone keys x < y with x below 38 and y - x equal to 7.
  localparam logic [5:0] ChordBaseLimit = 6'd38;
  localparam logic [5:0] ChordSpan      = 6'd7;

  typedef struct packed {
    logic [5:0] position;
    logic       is_chord;
    logic       pressed;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a new snapshot and restart the walk
    logic step;    // process the position under the walk index
    logic second;  // push the held release word of a judged key set
    logic flush;   // move the pending word to the output, marked last
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic gen;         // current position produces at least one word
    logic gen_double;  // current position produces a press and a release
    logic can_push;    // the pending stage can take a new word now
    logic out_free;    // the output register can take a word now
    logic pend_valid;  // a word waits in the pending stage
    logic walk_done;   // all 64 positions have been processed
  } status_t;

endpackage

`default_nettype wire

[design/mkcc_datapath.sv]
`default_nettype none

module mkcc_datapath (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire  [63:0]         key_state_i,
  input  wire  [3:0]          pair_skip_i,
  input  mkcc_pkg::cmd_t      cmd_i,
  output mkcc_pkg::status_t   status_o,
  input  wire                 out_ready_i,
  output logic                out_valid_o,
  output logic [5:0]          position_o,
  output logic                is_chord_o,
  output logic                pressed_o,
  output logic                last_o
);
  import mkcc_pkg::*;

  logic [63:0] snap_q, prev_q, prev_d, down_q, down_d, cum_q, cum_d;
  logic [3:0]  skip_q;
  logic [6:0]  idx_q, idx_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [5:0]  a_q, a_d, b_q, b_d;
  result_t     hold_q, hold_d, pend_q, pend_d, out_q, out_d;
  logic        pend_v_q, pend_v_d, out_v_q, out_v_d, last_q, last_d;

  logic [5:0]  key, x, y;
  logic [63:0] key_bit, down_after;
  logic        zone, skipped, cur_down, flip, down_empty, chord_ok;
  logic        gen_single, gen_pair, push_en, move;
  result_t     gen_res, new_res;

  // The walk index runs pair, then column half, then row; the key is row*8+col.
  assign key        = {idx_q[2:0], idx_q[5:3]};
  assign zone       = (key < KeyZoneLimit) && (key[2:0] < ColZoneLimit);
  assign skipped    = skip_q[idx_q[5:4]];
  assign cur_down   = snap_q[key];
  assign flip       = !skipped && (snap_q[key] ^ prev_q[key]);
  assign key_bit    = 64'd1 << key;
  assign down_after = down_q & ~key_bit;
  assign down_empty = (down_after == '0);

  assign x        = (a_q < b_q) ? a_q : b_q;
  assign y        = (a_q < b_q) ? b_q : a_q;
  assign chord_ok = (cnt_q == 2'd2) && (x < ChordBaseLimit) && ((y - x) == ChordSpan);

  assign gen_single = flip && !zone;
  assign gen_pair   = flip && zone && !cur_down && down_empty &&
                      ((cnt_q == 2'd1) || chord_ok);

  always_comb begin
    if (gen_single) begin
      gen_res = '{position: key, is_chord: 1'b0, pressed: cur_down};
    end else if (cnt_q == 2'd1) begin
      gen_res = '{position: a_q, is_chord: 1'b0, pressed: 1'b1};
    end else begin
      gen_res = '{position: x, is_chord: 1'b1, pressed: 1'b1};
    end
  end

  assign push_en = (cmd_i.step && (gen_single || gen_pair)) || cmd_i.second;
  assign new_res = cmd_i.second ? hold_q : gen_res;
  assign move    = (push_en && pend_v_q) || cmd_i.flush;

  always_comb begin
    idx_d    = idx_q;
    prev_d   = prev_q;
    down_d   = down_q;
    cum_d    = cum_q;
    cnt_d    = cnt_q;
    a_d      = a_q;
    b_d      = b_q;
    hold_d   = hold_q;
    pend_v_d = pend_v_q;
    pend_d   = pend_q;
    out_v_d  = out_v_q;
    out_d    = out_q;
    last_d   = last_q;

    if (cmd_i.load) begin
      idx_d = '0;
    end
    if (cmd_i.step) begin
      idx_d = idx_q + 7'd1;
      if (!skipped) begin
        prev_d[key] = snap_q[key];
      end
      if (flip && zone) begin
        if (cur_down) begin
          down_d = down_q | key_bit;
          if (!cum_q[key]) begin
            cum_d = cum_q | key_bit;
            // Only the first two distinct keys matter; the count saturates at three.
            case (cnt_q)
              2'd0: begin
                a_d   = key;
                cnt_d = 2'd1;
              end
              2'd1: begin
                b_d   = key;
                cnt_d = 2'd2;
              end
              default: cnt_d = 2'd3;
            endcase
          end
        end else begin
          down_d = down_after;
          if (down_empty) begin
            cum_d = '0;
            cnt_d = 2'd0;
          end
        end
      end
      if (gen_pair) begin
        hold_d         = gen_res;
        hold_d.pressed = 1'b0;
      end
    end

    // One word is held back so that the final word of a snapshot can carry last.
    if (push_en) begin
      pend_v_d = 1'b1;
      pend_d   = new_res;
    end else if (cmd_i.flush) begin
      pend_v_d = 1'b0;
    end

    if (move) begin
      out_v_d = 1'b1;
      out_d   = pend_q;
      last_d  = cmd_i.flush;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      prev_q   <= '0;
      down_q   <= '0;
      cum_q    <= '0;
      cnt_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      prev_q   <= prev_d;
      down_q   <= down_d;
      cum_q    <= cum_d;
      cnt_q    <= cnt_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      snap_q <= key_state_i;
      skip_q <= pair_skip_i;
    end
    a_q    <= a_d;
    b_q    <= b_d;
    hold_q <= hold_d;
    pend_q <= pend_d;
    out_q  <= out_d;
    last_q <= last_d;
  end

  assign status_o.gen        = gen_single || gen_pair;
  assign status_o.gen_double = gen_pair;
  assign status_o.out_free   = !out_v_q || out_ready_i;
  assign status_o.can_push   = !pend_v_q || !out_v_q || out_ready_i;
  assign status_o.pend_valid = pend_v_q;
  assign status_o.walk_done  = idx_q[6];

  assign out_valid_o = out_v_q;
  assign position_o  = out_q.position;
  assign is_chord_o  = out_q.is_chord;
  assign pressed_o   = out_q.pressed;
  assign last_o      = last_q;

endmodule

`default_nettype wire

[design/mkcc_controller.sv]
`default_nettype none

module mkcc_controller (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  mkcc_pkg::status_t  status_i,
  output mkcc_pkg::cmd_t     cmd_o
);
  import mkcc_pkg::*;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StWalk   = 4'b0010,
    StSecond = 4'b0100,
    StFlush  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StWalk;
        end
      end
      StWalk: begin
        if (status_i.walk_done) begin
          state_d = StFlush;
        end else if (!status_i.gen || status_i.can_push) begin
          cmd_o.step = 1'b1;
          if (status_i.gen_double) begin
            state_d = StSecond;
          end
        end
      end
      StSecond: begin
        if (status_i.can_push) begin
          cmd_o.second = 1'b1;
          state_d      = StWalk;
        end
      end
      StFlush: begin
        if (!status_i.pend_valid) begin
          state_d = StIdle;
        end else if (status_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == StIdle);

endmodule

`default_nettype wire

[design/matrix_keypad_chord_combiner.sv]
// Channel  Direction  Handshake                 Word
// in       input      in_valid_i / in_ready_o   key_state_i, pair_skip_i
// out      output     out_valid_o / out_ready_i position_o, is_chord_o, pressed_o, last_o
//
// After a word is accepted, in_ready_o stays low while the block walks all 64 positions,
// sees the walk end and flushes any pending word, and also while it pushes each second
// word of a judged key set.
// Output stalls stretch the walk: a position that produces a word waits until the
// one-word pending stage can drain into the output register, and so does the flush.
// Reset clears the matrix history, the zone masks and all handshake state.
`default_nettype none

module matrix_keypad_chord_combiner (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [63:0] key_state_i,
  input  wire  [3:0]  pair_skip_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [5:0]  position_o,
  output logic        is_chord_o,
  output logic        pressed_o,
  output logic        last_o
);
  import mkcc_pkg::*;

  cmd_t    cmd;
  status_t status;

  mkcc_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mkcc_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_state_i (key_state_i),
    .pair_skip_i (pair_skip_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .position_o  (position_o),
    .is_chord_o  (is_chord_o),
    .pressed_o   (pressed_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

[design/mkcc_checker.sv]
`default_nettype none

module mkcc_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_ready_o,
  input wire       out_valid_o,
  input wire       out_ready_i,
  input wire [5:0] position_o,
  input wire       is_chord_o,
  input wire       last_o
);

  // A snapshot occupies the block until its walk is over.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a snapshot was still being walked");

  // A word that is not the last of its snapshot means the walk is still running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("ready for a new snapshot before the last word was produced");

  // Chords only start below position 38.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_chord_o |-> position_o < 6'd38)
    else $error("chord reported at an impossible position");

  // A stalled output word stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word withdrawn before it was taken");

endmodule

bind matrix_keypad_chord_combiner mkcc_checker u_mkcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .position_o  (position_o),
  .is_chord_o  (is_chord_o),
  .last_o      (last_o)
);

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import mkcc_pkg::*;

  typedef struct packed {
    bit [5:0] position;
    bit       is_chord;
    bit       pressed;
    bit       last;
  } key_report_t;

  typedef struct packed {
    bit [63:0] snapshot;
    bit [3:0]  skip;
    bit        drain;
  } scan_item_t;

  localparam int RandomScans = 330;
  localparam int StallLimit  = 4000;
  localparam int SettleCycles = 150;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [63:0] key_state_i = '0;
  logic [3:0]  pair_skip_i = '0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [5:0]  position_o;
  logic        is_chord_o;
  logic        pressed_o;
  logic        last_o;

  matrix_keypad_chord_combiner u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .key_state_i (key_state_i),
    .pair_skip_i (pair_skip_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .position_o  (position_o),
    .is_chord_o  (is_chord_o),
    .pressed_o   (pressed_o),
    .last_o      (last_o)
  );

  scan_item_t  scan_q[$];
  key_report_t report_q[$];
  key_report_t scan_words[$];
  scan_item_t  next_scan;
  key_report_t seen_word;
  key_report_t due_word;

  // Predictor state.
  bit [63:0] prev_matrix;
  bit [63:0] zone_down;
  bit [63:0] zone_cum;

  bit [63:0] zone_map;
  bit [63:0] last_snapshot;
  int        scans_taken = 0;
  int        mismatches = 0;
  int        stall_cycles = 0;

  // Both sides stop idling for a stretch in the middle of the run.
  wire quiet = (scans_taken >= 120) && (scans_taken < 200);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic void add_report(input bit [5:0] pos, input bit chord, input bit down);
    key_report_t w;
    w.position = pos;
    w.is_chord = chord;
    w.pressed  = down;
    w.last     = 1'b0;
    scan_words.push_back(w);
  endfunction

  function automatic void handle_key(input bit [5:0] key, input bit down);
    int unsigned x;
    int unsigned y;
    if (key >= KeyZoneLimit || key[2:0] >= ColZoneLimit) begin
      add_report(key, 1'b0, down);
    end else if (down) begin
      zone_down[key] = 1'b1;
      zone_cum[key]  = 1'b1;
    end else begin
      zone_down[key] = 1'b0;
      if (zone_down == '0) begin
        if ($countones(zone_cum) == 1) begin
          add_report(key, 1'b0, 1'b1);
          add_report(key, 1'b0, 1'b0);
        end else if ($countones(zone_cum) == 2) begin
          x = 0;
          while (!zone_cum[x]) x++;
          y = x + 1;
          while (!zone_cum[y]) y++;
          if (x < ChordBaseLimit && y - x == ChordSpan) begin
            add_report(x[5:0], 1'b1, 1'b1);
            add_report(x[5:0], 1'b1, 1'b0);
          end
        end
        zone_cum = '0;
      end
    end
  endfunction

  // Walks the changed positions of one snapshot and queues the words it causes.
  function automatic void predict_scan(input bit [63:0] snap, input bit [3:0] skip);
    bit [63:0] pair_mask;
    bit [63:0] flip;
    int        key;
    scan_words.delete();
    for (int p = 0; p < 4; p++) begin
      if (!skip[p]) begin
        pair_mask = '0;
        for (int r = 0; r < 8; r++) begin
          pair_mask[r * 8 + 2 * p]     = 1'b1;
          pair_mask[r * 8 + 2 * p + 1] = 1'b1;
        end
        flip = (snap ^ prev_matrix) & pair_mask;
        prev_matrix = (prev_matrix & ~pair_mask) | (snap & pair_mask);
        for (int h = 0; h < 2; h++) begin
          for (int r = 0; r < 8; r++) begin
            key = r * 8 + 2 * p + h;
            if (flip[key]) handle_key(key[5:0], snap[key]);
          end
        end
      end
    end
    if (scan_words.size() != 0) scan_words[scan_words.size() - 1].last = 1'b1;
    foreach (scan_words[i]) report_q.push_back(scan_words[i]);
  endfunction

  function automatic bit [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic int unsigned zone_key();
    int unsigned k;
    k = $urandom_range(47);
    while (!zone_map[k]) k = $urandom_range(47);
    return k;
  endfunction

  function automatic bit [63:0] outer_noise();
    if ($urandom_range(3) == 0) return rand64() & rand64() & rand64() & ~zone_map;
    return '0;
  endfunction

  function automatic bit [3:0] sparse_skip();
    if ($urandom_range(7) == 0) return 4'($urandom_range(15));
    return 4'h0;
  endfunction

  task automatic push_scan(input bit [63:0] snap, input bit [3:0] skip, input bit drain);
    scan_item_t s;
    s.snapshot = snap;
    s.skip     = skip;
    s.drain    = drain;
    scan_q.push_back(s);
    last_snapshot = snap;
  endtask

  // One press-and-release of a zone key set, with outer keys toggling around it.
  task automatic run_gesture(input bit drain);
    bit [63:0]   keys;
    bit [63:0]   held;
    int unsigned k;
    int unsigned row;
    int unsigned col;
    keys = '0;
    held = '0;
    case ($urandom_range(3))
      0: begin
        keys[zone_key()] = 1'b1;
      end
      1, 2: begin
        row = $urandom_range(4);
        col = $urandom_range(5, 1);
        keys[row * 8 + col]     = 1'b1;
        keys[row * 8 + col + 7] = 1'b1;
      end
      default: begin
        repeat ($urandom_range(3, 2)) keys[zone_key()] = 1'b1;
      end
    endcase
    // Release every zone key first so that the gesture can empty the down set.
    push_scan((last_snapshot & ~zone_map) ^ outer_noise(), 4'h0, drain);
    while (held != keys) begin
      if ($urandom_range(1)) begin
        held = keys;
      end else begin
        k = $urandom_range(63);
        while (!keys[k] || held[k]) k = $urandom_range(63);
        held[k] = 1'b1;
      end
      push_scan(((last_snapshot & ~zone_map) ^ outer_noise()) | held, sparse_skip(), 1'b0);
    end
    while (held != '0) begin
      if ($urandom_range(1) || $countones(held) == 1) begin
        held = '0;
      end else begin
        k = $urandom_range(63);
        while (!held[k]) k = $urandom_range(63);
        held[k] = 1'b0;
      end
      push_scan(((last_snapshot & ~zone_map) ^ outer_noise()) | held,
                held == '0 ? 4'h0 : sparse_skip(), 1'b0);
    end
  endtask

  // Driver: predicts each accepted word, then offers the next pending one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_scan(key_state_i, pair_skip_i);
        scans_taken <= scans_taken + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (scan_q.size() != 0 && !(scan_q[0].drain && report_q.size() != 0) &&
            (quiet || $urandom_range(99) >= 31)) begin
          next_scan = scan_q.pop_front();
          key_state_i <= next_scan.snapshot;
          pair_skip_i <= next_scan.skip;
          in_valid_i  <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: every accepted output word is checked against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        seen_word.position = position_o;
        seen_word.is_chord = is_chord_o;
        seen_word.pressed  = pressed_o;
        seen_word.last     = last_o;
        if (report_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: pos %0d chord %b pressed %b last %b",
                     seen_word.position, seen_word.is_chord, seen_word.pressed,
                     seen_word.last);
        end else begin
          due_word = report_q.pop_front();
          if (seen_word != due_word) begin
            mismatches++;
            // Fields are shown as position/chord/pressed/last.
            if (mismatches <= 10)
              $display("mismatch: expected %0d/%b/%b/%b, got %0d/%b/%b/%b",
                       due_word.position, due_word.is_chord, due_word.pressed,
                       due_word.last, seen_word.position, seen_word.is_chord,
                       seen_word.pressed, seen_word.last);
          end
        end
      end
      out_ready_i <= quiet || ($urandom_range(99) >= 31);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    bit [5:0] kk;
    int       directed;
    int       gestures;
    prev_matrix = '0;
    zone_down   = '0;
    zone_cum    = '0;
    last_snapshot = '0;
    for (int k = 0; k < 64; k++) begin
      kk = 6'(k);
      zone_map[k] = (kk < KeyZoneLimit) && (kk[2:0] < ColZoneLimit);
    end

    // Directed part.
    push_scan('0, 4'h0, 1'b0);                      // unchanged snapshot
    push_scan('1, 4'h0, 1'b0);                      // every key down at once
    push_scan('0, 4'h0, 1'b0);                      // large zone set: no report
    push_scan(64'd1, 4'h0, 1'b0);
    push_scan(~zone_map, 4'h0, 1'b0);               // single release plus all outer presses
    push_scan('0, 4'hF, 1'b0);                      // every pair skipped
    push_scan('0, 4'h0, 1'b1);
    push_scan((64'd1 << 1) | (64'd1 << 8), 4'h0, 1'b0);
    push_scan('0, 4'h0, 1'b0);                      // chord at 1
    push_scan(64'd1 << 37, 4'h0, 1'b0);
    push_scan((64'd1 << 37) | (64'd1 << 44), 4'h0, 1'b0);
    push_scan(64'd1 << 44, 4'h0, 1'b0);
    push_scan('0, 4'h0, 1'b0);                      // highest chord base
    push_scan((64'd1 << 2) | (64'd1 << 10), 4'h0, 1'b0);
    push_scan('0, 4'h0, 1'b0);                      // two keys, not a chord
    push_scan((64'd1 << 1) | (64'd1 << 8) | (64'd1 << 15), 4'h0, 1'b0);
    push_scan('0, 4'h0, 1'b0);                      // three keys
    push_scan((64'd1 << 3) | (64'd1 << 63), 4'b0010, 1'b0);
    push_scan((64'd1 << 3) | (64'd1 << 63), 4'h0, 1'b0);
    push_scan('0, 4'h0, 1'b0);
    directed = scan_q.size();

    gestures = 0;
    while (scan_q.size() < directed + RandomScans) begin
      if ($urandom_range(99) < 75) begin
        run_gesture(gestures % 30 == 29);
        gestures++;
      end else begin
        case ($urandom_range(2))
          0: push_scan(rand64(), 4'($urandom_range(15)), 1'b0);
          1: push_scan(last_snapshot ^ (64'd1 << $urandom_range(63)), sparse_skip(), 1'b0);
          default: push_scan(last_snapshot, 4'($urandom_range(15)), 1'b0);
        endcase
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(posedge clk_i);
    while (scan_q.size() != 0 || in_valid_i || report_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0 && report_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
